>>> hdl/nfid_pkg.sv
// Package for the next-fit handle slot table.
// Holds the request and response payload types, the action codes and the defaults.
// No dependencies.
package nfid_pkg;

    // Field widths of the request and response payloads
    localparam int ACTION_W = 3;
    localparam int SLOT_ID_W = 10;
    localparam int VALUE_W = 32;
    localparam int SIZE_W = 11;

    // Defaults for the top-level parameters and the size register
    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_HANDLE_WIDTH = 32;
    localparam int CFG_SIZE_RST = 1024;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ALLOC_STORE   = 3'd0,
        ACT_ALLOC_RESERVE = 3'd1,
        ACT_WRITE         = 3'd2,
        ACT_DELETE        = 3'd3,
        ACT_DELETE_MATCH  = 3'd4,
        ACT_READ          = 3'd5,
        ACT_SET_IF_EMPTY  = 3'd6,
        ACT_FIND          = 3'd7
    } t_action;

    typedef struct packed {
        t_action                action;
        logic [SLOT_ID_W-1:0]   slot_id;
        logic [VALUE_W-1:0]     value;
    } t_req;

    typedef struct packed {
        logic                   ok;
        logic [SLOT_ID_W-1:0]   result_id;
        logic [VALUE_W-1:0]     read_value;
        logic [SIZE_W-1:0]      occupied_count;
    } t_rsp;

    // Finished response offered by the engine to the output register
    typedef struct packed {
        logic                   valid;
        t_rsp                   rsp;
    } t_eng_res;

endpackage

>>> hdl/next_fit_id_slot_table.sv
// Next-fit handle slot table, top level: size register, engine and response register.
// Depends on nfid_pkg and nfid_engine.
// Single-slot actions pass through the look, evaluate and done states; allocation and
// find scan the slots, one slot probed per cycle, at most table size probes.
// One request at a time: the next is taken once the response register has accepted the last.
// Reset: synchronous; a clearing pass zeroes the store, no request
// is taken meanwhile; size register returns to 1024, saturated at TABLE_DEPTH.
module next_fit_id_slot_table
    import nfid_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int HANDLE_WIDTH = DEF_HANDLE_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    output logic                o_req_ready,
    input  t_req                i_req,
    output logic                o_rsp_valid,
    input  logic                i_rsp_ready,
    output t_rsp                o_rsp,
    input  logic                i_cfg_we,
    input  logic [SIZE_W-1:0]   i_cfg_wdata
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int SIZE_RST = (TABLE_DEPTH < CFG_SIZE_RST) ? TABLE_DEPTH : CFG_SIZE_RST;

    logic [CW-1:0]  r_size, n_size;
    logic           r_rsp_valid, n_rsp_valid;
    t_rsp           r_rsp, n_rsp;
    t_eng_res       eng_res;
    logic           res_take;

    // Saturate the written size at the table depth
    always_comb begin
        n_size = r_size;
        if (i_cfg_we) begin
            if (32'(i_cfg_wdata) > 32'(TABLE_DEPTH)) begin
                n_size = CW'(TABLE_DEPTH);
            end else begin
                n_size = CW'(i_cfg_wdata);
            end
        end
    end

    // Load the response register when empty or being drained
    assign res_take = eng_res.valid && (!r_rsp_valid || i_rsp_ready);

    always_comb begin
        n_rsp_valid = r_rsp_valid;
        n_rsp       = r_rsp;
        if (res_take) begin
            n_rsp_valid = 1'b1;
            n_rsp       = eng_res.rsp;
        end else if (i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= CW'(SIZE_RST);
            r_rsp_valid <= 1'b0;
        end else begin
            r_size      <= n_size;
            r_rsp_valid <= n_rsp_valid;
        end
        r_rsp <= n_rsp;
    end

    nfid_engine #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .HANDLE_WIDTH (HANDLE_WIDTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .i_size      (r_size),
        .o_res       (eng_res),
        .i_res_take  (res_take)
    );

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

>>> hdl/nfid_engine.sv
// Sequencer, slot store and shared compare unit of the next-fit handle slot table.
// Depends on nfid_pkg for the payload types and action codes.
module nfid_engine
    import nfid_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int HANDLE_WIDTH = DEF_HANDLE_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_req_valid,
    output logic                                o_req_ready,
    input  t_req                                i_req,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]    i_size,
    output t_eng_res                            o_res,
    input  logic                                i_res_take
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef logic [HANDLE_WIDTH-1:0] t_handle;
    typedef logic [IW-1:0] t_idx;
    typedef logic [CW-1:0] t_cnt;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_EVAL,
        ST_SCAN,
        ST_DONE
    } t_state;

    t_state   r_state, n_state;
    t_action  r_act, n_act;
    t_handle  r_key, n_key;
    logic     r_id_ok, n_id_ok;
    logic     r_id_nz, n_id_nz;
    t_idx     r_addr, n_addr;
    t_idx     r_chk, n_chk;
    logic     r_chk_v, n_chk_v;
    t_cnt     r_issued, n_issued;
    t_cnt     r_evals, n_evals;
    t_cnt     r_limit, n_limit;
    t_idx     r_cursor, n_cursor;
    t_cnt     r_count, n_count;
    t_rsp     r_res, n_res;

    t_handle  r_slot_mem [TABLE_DEPTH];
    t_handle  r_rdata;

    logic     wr_en;
    t_idx     wr_addr;
    t_handle  wr_data;

    t_handle  cmp_key;
    logic     match;
    logic     size_small;
    t_idx     cursor0;
    t_cnt     cnt_up;
    t_cnt     cnt_dn;
    t_rsp     fail_rsp;
    logic     act_ok;
    logic     act_wr;
    logic     act_dn;

    // Next-fit step: advance, wrapping to slot 1 at the size
    function automatic t_idx wrap_next(input t_idx c, input t_cnt sz);
        t_cnt inc;
        inc = CW'(c) + 1'b1;
        return (inc >= sz) ? IW'(1) : IW'(inc);
    endfunction

    // Slot store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slot_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_slot_mem[r_addr];
    end

    // Shared compare unit: free-slot test, match test and search all use it
    always_comb begin
        if (r_act == ACT_ALLOC_STORE || r_act == ACT_ALLOC_RESERVE ||
            r_act == ACT_DELETE || r_act == ACT_SET_IF_EMPTY) begin
            cmp_key = '0;
        end else begin
            cmp_key = r_key;
        end
    end
    assign match = (r_rdata == cmp_key);

    // Saturating occupancy steps
    assign cnt_up = (r_count == CW'(TABLE_DEPTH)) ? r_count : r_count + 1'b1;
    assign cnt_dn = (r_count == '0) ? r_count : r_count - 1'b1;

    assign size_small = (i_size < CW'(2));
    assign cursor0 = (CW'(r_cursor) >= i_size) ? '0 : r_cursor;
    assign fail_rsp = '{ok: 1'b0, result_id: '0, read_value: '0,
                        occupied_count: SIZE_W'(r_count)};

    // Single-slot decision on the data read back
    always_comb begin
        act_ok = 1'b0;
        act_wr = 1'b0;
        act_dn = 1'b0;
        unique case (r_act)
            ACT_WRITE: begin
                act_ok = r_id_ok;
                act_wr = r_id_ok;
            end
            ACT_DELETE: begin
                act_ok = r_id_ok && r_id_nz && !match;
                act_wr = act_ok;
                act_dn = act_ok;
            end
            ACT_DELETE_MATCH: begin
                act_ok = r_id_ok && r_id_nz && match;
                act_wr = act_ok;
                act_dn = act_ok;
            end
            ACT_READ: begin
                act_ok = r_id_ok;
            end
            ACT_SET_IF_EMPTY: begin
                act_ok = r_id_ok && match;
                act_wr = act_ok;
            end
            ACT_ALLOC_STORE, ACT_ALLOC_RESERVE, ACT_FIND: begin
                act_ok = 1'b0;
            end
        endcase
    end

    // Sequencer: clearing pass, request capture, single-slot access and slot scan
    always_comb begin
        n_state  = r_state;
        n_act    = r_act;
        n_key    = r_key;
        n_id_ok  = r_id_ok;
        n_id_nz  = r_id_nz;
        n_addr   = r_addr;
        n_chk    = r_chk;
        n_chk_v  = 1'b0;
        n_issued = r_issued;
        n_evals  = r_evals;
        n_limit  = r_limit;
        n_cursor = r_cursor;
        n_count  = r_count;
        n_res    = r_res;
        wr_en    = 1'b0;
        wr_addr  = r_chk;
        wr_data  = r_key;

        unique case (r_state)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_addr;
                wr_data = '0;
                n_addr  = r_addr + 1'b1;
                if (r_addr == IW'(TABLE_DEPTH - 1)) begin
                    n_addr  = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_act    = i_req.action;
                    n_key    = HANDLE_WIDTH'(i_req.value);
                    n_id_ok  = (32'(i_req.slot_id) < 32'(i_size));
                    n_id_nz  = (i_req.slot_id != '0);
                    n_issued = '0;
                    n_evals  = '0;
                    unique case (i_req.action)
                        ACT_ALLOC_STORE, ACT_ALLOC_RESERVE: begin
                            if (size_small) begin
                                n_res   = fail_rsp;
                                n_state = ST_DONE;
                            end else begin
                                n_addr  = wrap_next(cursor0, i_size);
                                n_limit = i_size;
                                n_state = ST_SCAN;
                            end
                        end
                        ACT_FIND: begin
                            if (size_small) begin
                                n_res   = fail_rsp;
                                n_state = ST_DONE;
                            end else begin
                                n_addr  = IW'(1);
                                n_limit = i_size - 1'b1;
                                n_state = ST_SCAN;
                            end
                        end
                        default: begin
                            n_addr  = IW'(i_req.slot_id);
                            n_state = ST_LOOK;
                        end
                    endcase
                end
            end
            ST_LOOK: begin
                n_chk   = r_addr;
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                wr_en   = act_wr;
                wr_data = act_dn ? '0 : r_key;
                n_count = act_dn ? cnt_dn : r_count;
                n_res.ok             = act_ok;
                n_res.result_id      = act_ok ? SLOT_ID_W'(r_chk) : '0;
                n_res.read_value     = (act_ok && r_act == ACT_READ) ?
                                       VALUE_W'(r_rdata) : '0;
                n_res.occupied_count = SIZE_W'(n_count);
                n_state = ST_DONE;
            end
            ST_SCAN: begin
                // issue the next probe while the previous one is checked
                if (r_issued < r_limit) begin
                    n_chk    = r_addr;
                    n_chk_v  = 1'b1;
                    n_issued = r_issued + 1'b1;
                    n_addr   = (r_act == ACT_FIND) ? r_addr + 1'b1 :
                               wrap_next(r_addr, i_size);
                end
                if (r_chk_v) begin
                    if (match) begin
                        if (r_act != ACT_FIND) begin
                            n_cursor = r_chk;
                            n_count  = cnt_up;
                        end
                        wr_en   = (r_act == ACT_ALLOC_STORE);
                        wr_addr = r_chk;
                        n_res.ok             = 1'b1;
                        n_res.result_id      = SLOT_ID_W'(r_chk);
                        n_res.read_value     = '0;
                        n_res.occupied_count = SIZE_W'(n_count);
                        n_chk_v = 1'b0;
                        n_state = ST_DONE;
                    end else if (r_evals == r_limit - 1'b1) begin
                        if (r_act != ACT_FIND) begin
                            n_cursor = r_chk;
                        end
                        n_res   = fail_rsp;
                        n_chk_v = 1'b0;
                        n_state = ST_DONE;
                    end else begin
                        n_evals = r_evals + 1'b1;
                    end
                end
            end
            ST_DONE: begin
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_addr   <= '0;
            r_chk_v  <= 1'b0;
            r_cursor <= '0;
            r_count  <= '0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_chk_v  <= n_chk_v;
            r_cursor <= n_cursor;
            r_count  <= n_count;
        end
        r_act    <= n_act;
        r_key    <= n_key;
        r_id_ok  <= n_id_ok;
        r_id_nz  <= n_id_nz;
        r_chk    <= n_chk;
        r_issued <= n_issued;
        r_evals  <= n_evals;
        r_limit  <= n_limit;
        r_res    <= n_res;
    end

    assign o_req_ready = (r_state == ST_IDLE);
    assign o_res.valid = (r_state == ST_DONE);
    assign o_res.rsp   = r_res;

    // Occupancy never passes the table depth
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("occupancy count beyond table depth");

    // Scan counters stay within the probe limit
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCAN |-> (r_evals < r_limit && r_issued <= r_limit))
        else $error("scan probe counters out of range");

    // A pending probe check exists only while scanning
    a_chk_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk_v |-> r_state == ST_SCAN)
        else $error("probe check pending outside scan");

    // A successful allocation never hands out slot zero
    a_alloc_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_res.ok &&
         (r_act == ACT_ALLOC_STORE || r_act == ACT_ALLOC_RESERVE)) |-> r_chk != '0)
        else $error("allocation returned slot zero");

    // Occupancy holds across request capture
    a_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |=> $stable(r_count))
        else $error("occupancy changed on request capture");

endmodule
